// ===== rtl/srid_pkg.sv =====
package srid_pkg;

	// width of the value field on the result stream
	localparam int unsigned ValueW = 32;

	// configuration register width and index width
	localparam int unsigned CfgW = 5;
	localparam int unsigned CfgIdxW = 1;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegRootBits = 1'd0;
	localparam logic [CfgIdxW-1:0] RegStartBit = 1'd1;

	// reset value of the start position
	localparam logic [2:0] StartBitReset = 3'd7;

	// one decoded result
	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              ovf;
	} res_t;

endpackage

// ===== rtl/srid_bit_unit.sv =====
module srid_bit_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             step,
	input  logic             bit_in,
	input  logic [4:0]       root_bits,
	output logic             emit,
	output srid_pkg::res_t   res
);

	localparam int unsigned ExtW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	logic                  in_payload_q;
	logic [5:0]            ones_q;
	logic [6:0]            left_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  ovf_q;

	logic                  ones_nz;
	logic [6:0]            pay_len;
	logic [6:0]            total_len;
	logic                  ovf_new;
	logic [VALUE_BITS-1:0] acc_shift;
	logic [VALUE_BITS-1:0] acc_src;
	logic                  ovf_src;
	logic [ExtW-1:0]       acc_ext;

	// payload length and overflow test at the end of the prefix
	assign ones_nz   = (ones_q != 6'd0);
	assign pay_len   = 7'(root_bits) + (ones_nz ? (7'(ones_q) - 7'd1) : 7'd0);
	assign total_len = 7'(root_bits) + 7'(ones_q);
	assign ovf_new   = (total_len > 7'(VALUE_BITS));
	assign acc_shift = {acc_q[VALUE_BITS-2:0], bit_in};

	// does this bit finish a code
	assign emit = in_payload_q ? (left_q == 7'd1) : (!bit_in && (pay_len == 7'd0));

	// result of a finishing bit, all ones on overflow
	always_comb begin
		if (in_payload_q) begin
			acc_src = acc_shift;
			ovf_src = ovf_q;
		end else begin
			acc_src = VALUE_BITS'(ones_nz);
			ovf_src = ovf_new;
		end
		acc_ext   = ExtW'(ovf_src ? {VALUE_BITS{1'b1}} : acc_src);
		res.value = acc_ext[srid_pkg::ValueW-1:0];
		res.ovf   = ovf_src;
	end

	// code state, one bit per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			ones_q       <= '0;
			left_q       <= '0;
			acc_q        <= '0;
			ovf_q        <= 1'b0;
		end else if (clear) begin
			in_payload_q <= 1'b0;
			ones_q       <= '0;
			left_q       <= '0;
			acc_q        <= '0;
			ovf_q        <= 1'b0;
		end else if (step) begin
			if (!in_payload_q) begin
				if (bit_in) begin
					if (ones_q != 6'h3f) begin
						ones_q <= ones_q + 6'd1;
					end
				end else begin
					ones_q <= '0;
					ovf_q  <= ovf_new;
					acc_q  <= VALUE_BITS'(ones_nz);
					if (pay_len != 7'd0) begin
						in_payload_q <= 1'b1;
						left_q       <= pay_len;
					end
				end
			end else begin
				acc_q  <= acc_shift;
				left_q <= left_q - 7'd1;
				if (emit) begin
					in_payload_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/srid_out_stage.sv =====
module srid_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  srid_pkg::res_t              push_res,
	input  logic                        flush,
	output logic                        room,
	output logic                        flush_done,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [srid_pkg::ValueW-1:0] m_axis_tdata,  // value
	output logic                        m_axis_tuser,  // overflow
	output logic                        m_axis_tlast
);

	logic           pend_valid_q;
	srid_pkg::res_t pend_q;
	logic           out_valid_q;
	srid_pkg::res_t out_q;
	logic           out_last_q;
	logic           out_free;
	logic           move;

	// a held result moves on to the free output register only as a new result comes in or on a flush
	assign out_free   = !out_valid_q || m_axis_tready;
	assign room       = !pend_valid_q || out_free;
	assign flush_done = room;
	assign move       = pend_valid_q && (push || flush) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (push && room) begin
				pend_valid_q <= 1'b1;
			end else if (flush && room) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload, the last result of a byte goes out on the flush
	always_ff @(posedge clk) begin
		if (move) begin
			out_q      <= pend_q;
			out_last_q <= flush;
		end
		if (push && room) begin
			pend_q <= push_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.value;
	assign m_axis_tuser  = out_q.ovf;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/scale_root_int_decoder.sv =====
// Scale-and-root integer code decoder (scale 2): takes one stream byte per
// transfer and walks its bits MSB first through a one-bit decode unit, one bit
// per clock while the bit walk is not stalled, from its first position down to
// bit 0, then closes the byte in a flush state. A stream's first byte starts at
// start_bit rather than bit 7. The input stays not ready from the accept until
// the flush is done; results wait in a holding register and an output
// register, and the bit walk stalls only when both are full. Each byte may give
// zero to eight results; tlast marks the last result of a byte.
module scale_root_int_decoder #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [srid_pkg::CfgIdxW-1:0]  cfg_addr,
	input  logic [srid_pkg::CfgW-1:0]     cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // stream_byte
	input  logic                          s_axis_tuser,  // new_stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [srid_pkg::ValueW-1:0]   m_axis_tdata,  // value
	output logic                          m_axis_tuser,  // overflow
	output logic                          m_axis_tlast   // last_in_byte
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t         state_q;
	logic [2:0]     pos_q;
	logic [7:0]     byte_q;
	logic           started_q;
	logic [4:0]     root_q;
	logic [2:0]     start_q;

	logic           in_xfer;
	logic           restart;
	logic           emit;
	logic           step;
	logic           room;
	logic           flush_done;
	srid_pkg::res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			start_q <= srid_pkg::StartBitReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				srid_pkg::RegRootBits: root_q  <= cfg_wdata;
				srid_pkg::RegStartBit: start_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign restart       = in_xfer && (s_axis_tuser || !started_q);
	assign step          = (state_q == ST_RUN) && (!emit || room);

	// bit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q   <= ST_RUN;
						started_q <= 1'b1;
						pos_q     <= restart ? start_q : 3'd7;
					end
				end
				ST_RUN: begin
					if (step) begin
						if (pos_q == 3'd0) begin
							state_q <= ST_FLUSH;
						end else begin
							pos_q <= pos_q - 3'd1;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// byte under decode
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q <= s_axis_tdata;
		end
	end

	srid_bit_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_bit (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (restart),
		.step     (step),
		.bit_in   (byte_q[pos_q]),
		.root_bits(root_q),
		.emit     (emit),
		.res      (res)
	);

	srid_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (step && emit),
		.push_res     (res),
		.flush        (state_q == ST_FLUSH),
		.room         (room),
		.flush_done   (flush_done),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// ===== rtl/srid_checker.sv =====
module srid_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [srid_pkg::ValueW-1:0] m_axis_tdata,
	input logic                        m_axis_tuser,
	input logic                        m_axis_tlast
);

	localparam int unsigned ExtW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
	localparam logic [ExtW-1:0] OnesExt = ExtW'({VALUE_BITS{1'b1}});
	localparam logic [srid_pkg::ValueW-1:0] OnesMask = OnesExt[srid_pkg::ValueW-1:0];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// an overflow result carries the all-ones value
	a_ovf_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == OnesMask))
		else $error("overflow result not all ones");

	// the decoder is busy right after taking a byte
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("byte taken while still decoding");

	// no result is valid straight out of reset
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid out of reset");

endmodule

bind scale_root_int_decoder srid_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_srid_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
